// ===== rtl/mbb_pkg.sv =====
package mbb_pkg;

    localparam int BOX_W     = 14;
    localparam int VOX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_DIM_DEF = 1024;

    localparam logic [BOX_W-1:0] BOX_EMPTY_MIN = BOX_W'(10000);

    localparam logic [CFG_W-1:0] SIZE_X_RST = CFG_W'(512);
    localparam logic [CFG_W-1:0] SIZE_Y_RST = CFG_W'(512);
    localparam logic [CFG_W-1:0] SIZE_Z_RST = CFG_W'(512);
    localparam logic [CFG_W-1:0] CLIP_RST   = CFG_W'(180);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_CLIP   = 2'd3
    } t_cfg_reg;

    // one registered voxel, coordinates already resolved
    typedef struct packed {
        logic             set;
        logic             clip;
        logic             last;
        logic [BOX_W-1:0] x;
        logic [BOX_W-1:0] y;
        logic [BOX_W-1:0] z;
    } t_vox;

    typedef struct packed {
        logic [BOX_W-1:0] x_min;
        logic [BOX_W-1:0] y_min;
        logic [BOX_W-1:0] z_min;
        logic [BOX_W-1:0] x_max;
        logic [BOX_W-1:0] y_max;
        logic [BOX_W-1:0] z_max;
    } t_box;

    localparam t_box BOX_EMPTY = '{
        x_min: BOX_EMPTY_MIN, y_min: BOX_EMPTY_MIN, z_min: BOX_EMPTY_MIN,
        x_max: '0, y_max: '0, z_max: '0
    };

endpackage

// ===== rtl/mbb_coord.sv =====
module mbb_coord #(
    parameter int MAX_DIM = mbb_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_advance,
    input  logic [mbb_pkg::VOX_W-1:0]   i_voxel,
    input  logic [mbb_pkg::CFG_W-1:0]   i_size_x,
    input  logic [mbb_pkg::CFG_W-1:0]   i_size_y,
    input  logic [mbb_pkg::CFG_W-1:0]   i_size_z,
    input  logic [mbb_pkg::CFG_W-1:0]   i_clip_depth,
    output logic                        o_valid,
    output mbb_pkg::t_vox               o_vox
);

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int BW = mbb_pkg::BOX_W;
    localparam logic [BW-1:0] MAX_DIM_W = BW'(MAX_DIM);

    logic [CW-1:0]   r_col, r_row, r_slice;
    logic [CW-1:0]   n_col, n_row, n_slice;
    logic            r_valid, n_valid;
    mbb_pkg::t_vox   r_vox, n_vox;
    logic [BW-1:0]   last_x, last_y, last_z;
    logic            end_x, end_y, end_z;

    // size 0 acts as 1, size above MAX_DIM acts as MAX_DIM
    function automatic logic [BW-1:0] last_index(input logic [mbb_pkg::CFG_W-1:0] size);
        logic [BW-1:0] s;
        s = BW'(size);
        if (s == '0) begin
            s = BW'(1);
        end
        if (s > MAX_DIM_W) begin
            s = MAX_DIM_W;
        end
        return s - BW'(1);
    endfunction

    always_comb begin
        last_x = last_index(i_size_x);
        last_y = last_index(i_size_y);
        last_z = last_index(i_size_z);
        end_x  = BW'(r_col)   >= last_x;
        end_y  = BW'(r_row)   >= last_y;
        end_z  = BW'(r_slice) >= last_z;
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_slice = r_slice;
        if (i_accept) begin
            if (end_x && end_y && end_z) begin
                n_col   = '0;
                n_row   = '0;
                n_slice = '0;
            end else if (!end_x) begin
                n_col = r_col + CW'(1);
            end else begin
                n_col = '0;
                if (!end_y) begin
                    n_row = r_row + CW'(1);
                end else begin
                    n_row   = '0;
                    n_slice = r_slice + CW'(1);
                end
            end
        end
    end

    always_comb begin
        n_vox      = r_vox;
        n_valid    = r_valid;
        if (i_advance) begin
            n_valid = 1'b0;
        end
        if (i_accept) begin
            n_valid    = 1'b1;
            n_vox.set  = !i_voxel[mbb_pkg::VOX_W-1] && (|i_voxel);
            n_vox.clip = BW'(r_slice) < BW'(i_clip_depth);
            n_vox.last = end_x && end_y && end_z;
            n_vox.x    = BW'(r_col);
            n_vox.y    = BW'(r_row);
            n_vox.z    = BW'(r_slice);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_slice <= n_slice;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vox <= n_vox;
    end

    assign o_valid = r_valid;
    assign o_vox   = r_vox;

endmodule

// ===== rtl/mbb_box.sv =====
module mbb_box (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_widen,
    input  logic                        i_clear,
    input  logic [mbb_pkg::BOX_W-1:0]   i_x,
    input  logic [mbb_pkg::BOX_W-1:0]   i_y,
    input  logic [mbb_pkg::BOX_W-1:0]   i_z,
    output mbb_pkg::t_box               o_box,
    output mbb_pkg::t_box               o_next
);

    mbb_pkg::t_box r_box, n_box, widened;

    always_comb begin
        widened       = r_box;
        widened.x_min = (i_x < r_box.x_min) ? i_x : r_box.x_min;
        widened.y_min = (i_y < r_box.y_min) ? i_y : r_box.y_min;
        widened.z_min = (i_z < r_box.z_min) ? i_z : r_box.z_min;
        widened.x_max = (i_x > r_box.x_max) ? i_x : r_box.x_max;
        widened.y_max = (i_y > r_box.y_max) ? i_y : r_box.y_max;
        widened.z_max = (i_z > r_box.z_max) ? i_z : r_box.z_max;
    end

    // o_next carries this voxel's update; clear drops it after capture
    assign o_next = i_widen ? widened : r_box;
    assign n_box  = i_clear ? mbb_pkg::BOX_EMPTY : o_next;
    assign o_box  = r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= mbb_pkg::BOX_EMPTY;
        end else begin
            r_box <= n_box;
        end
    end

endmodule

// ===== rtl/mask_bounding_box_tracker.sv =====
// Bounding box tracker for a 3D mask volume.
//
// Input channel: one signed voxel per request on i_valid / o_stall, raster
// order with x fastest, then y, then z. A voxel above zero is "set".
// Output channel: one request per volume on o_valid / i_stall, carrying the
// full box and the clipped box (slices with z below clip_depth). An empty box
// reads min 10000, max 0.
// Config: i_cfg_we / i_cfg_idx / i_cfg_data, write only, while idle.
//
// Throughput is one voxel per cycle while o_stall is low. A voxel enters the input
// register when it is accepted; the box update for the last voxel of a volume is
// loaded into the result register when that voxel leaves the input register,
// which sets o_valid.
// If the receiver stalls with a result pending, voxels keep flowing until the
// next volume's last voxel sits in the input register; only then is o_stall
// raised. Reset sets the sizes to 512, clip_depth to 180, empties both boxes
// and zeroes the coordinate counters.
module mask_bounding_box_tracker #(
    parameter int MAX_DIM = mbb_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // voxel input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [mbb_pkg::VOX_W-1:0] i_voxel,
    // config
    input  logic                            i_cfg_we,
    input  logic [mbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mbb_pkg::CFG_W-1:0]       i_cfg_data,
    // result output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mbb_pkg::BOX_W-1:0]       o_box_x_min,
    output logic [mbb_pkg::BOX_W-1:0]       o_box_y_min,
    output logic [mbb_pkg::BOX_W-1:0]       o_box_z_min,
    output logic [mbb_pkg::BOX_W-1:0]       o_box_x_max,
    output logic [mbb_pkg::BOX_W-1:0]       o_box_y_max,
    output logic [mbb_pkg::BOX_W-1:0]       o_box_z_max,
    output logic [mbb_pkg::BOX_W-1:0]       o_clip_x_min,
    output logic [mbb_pkg::BOX_W-1:0]       o_clip_y_min,
    output logic [mbb_pkg::BOX_W-1:0]       o_clip_z_min,
    output logic [mbb_pkg::BOX_W-1:0]       o_clip_x_max,
    output logic [mbb_pkg::BOX_W-1:0]       o_clip_y_max,
    output logic [mbb_pkg::BOX_W-1:0]       o_clip_z_max
);

    // config registers
    logic [mbb_pkg::CFG_W-1:0] r_size_x, r_size_y, r_size_z, r_clip_depth;

    // stage handshake
    logic          accept;
    logic          s1_valid;
    logic          s1_go;
    logic          out_free;
    mbb_pkg::t_vox s1_vox;

    // box accumulators
    mbb_pkg::t_box full_cur, full_next, clip_cur, clip_next;

    // result register
    logic          r_out_valid, n_out_valid;
    mbb_pkg::t_box r_out_full, r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x     <= mbb_pkg::SIZE_X_RST;
            r_size_y     <= mbb_pkg::SIZE_Y_RST;
            r_size_z     <= mbb_pkg::SIZE_Z_RST;
            r_clip_depth <= mbb_pkg::CLIP_RST;
        end else if (i_cfg_we) begin
            case (mbb_pkg::t_cfg_reg'(i_cfg_idx))
                mbb_pkg::REG_SIZE_X: r_size_x     <= i_cfg_data;
                mbb_pkg::REG_SIZE_Y: r_size_y     <= i_cfg_data;
                mbb_pkg::REG_SIZE_Z: r_size_z     <= i_cfg_data;
                mbb_pkg::REG_CLIP:   r_clip_depth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A voxel in the input register moves on unless it ends a volume and the
    // result register is still held by the receiver.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = s1_valid && (!s1_vox.last || out_free);
    assign o_stall  = s1_valid && !s1_go;
    assign accept   = i_valid && !o_stall;

    mbb_coord #(
        .MAX_DIM (MAX_DIM)
    ) u_coord (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_advance    (s1_go),
        .i_voxel      (i_voxel),
        .i_size_x     (r_size_x),
        .i_size_y     (r_size_y),
        .i_size_z     (r_size_z),
        .i_clip_depth (r_clip_depth),
        .o_valid      (s1_valid),
        .o_vox        (s1_vox)
    );

    mbb_box u_full_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_widen (s1_go && s1_vox.set),
        .i_clear (s1_go && s1_vox.last),
        .i_x     (s1_vox.x),
        .i_y     (s1_vox.y),
        .i_z     (s1_vox.z),
        .o_box   (full_cur),
        .o_next  (full_next)
    );

    mbb_box u_clip_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_widen (s1_go && s1_vox.set && s1_vox.clip),
        .i_clear (s1_go && s1_vox.last),
        .i_x     (s1_vox.x),
        .i_y     (s1_vox.y),
        .i_z     (s1_vox.z),
        .o_box   (clip_cur),
        .o_next  (clip_next)
    );

    // result register: loads on the last voxel, drains when not stalled
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (s1_go && s1_vox.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_vox.last) begin
            r_out_full <= full_next;
            r_out_clip <= clip_next;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_box_x_min  = r_out_full.x_min;
    assign o_box_y_min  = r_out_full.y_min;
    assign o_box_z_min  = r_out_full.z_min;
    assign o_box_x_max  = r_out_full.x_max;
    assign o_box_y_max  = r_out_full.y_max;
    assign o_box_z_max  = r_out_full.z_max;
    assign o_clip_x_min = r_out_clip.x_min;
    assign o_clip_y_min = r_out_clip.y_min;
    assign o_clip_z_min = r_out_clip.z_min;
    assign o_clip_x_max = r_out_clip.x_max;
    assign o_clip_y_max = r_out_clip.y_max;
    assign o_clip_z_max = r_out_clip.z_max;

    // a new result only follows a volume-ending voxel
    a_rise_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_valid && s1_vox.last))
        else $error("result appeared without a volume end");

    // input back-pressure only comes from a pending last voxel
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (s1_valid && s1_vox.last && r_out_valid && i_stall))
        else $error("stall raised without a blocked volume end");

    // boxes are empty right after a volume ends
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_vox.last) |=> (full_cur == mbb_pkg::BOX_EMPTY &&
                                    clip_cur == mbb_pkg::BOX_EMPTY))
        else $error("box not cleared after volume end");

    // a non-empty clipped box lies within the full box in x, and its z_max within the full z_max
    a_clip_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clip_x_min != mbb_pkg::BOX_EMPTY_MIN) |->
            (o_clip_x_min >= o_box_x_min && o_clip_x_max <= o_box_x_max &&
             o_clip_z_max <= o_box_z_max))
        else $error("clipped box outside full box");

endmodule
